// ----- hdl/fwr_pkg.sv -----
// Shared types, codes and constants for the FIFO with replace-all.
package fwr_pkg;

   localparam int DEPTH_DEFAULT = 128;
   localparam int DATA_W        = 32;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 2;
   localparam int LEVEL_W       = 8;

   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REPLACE = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   localparam logic signed [DATA_W-1:0] EMPTY_DATA = -32'sd1;
   localparam logic signed [DATA_W-1:0] ZERO_DATA  = 32'sd0;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [STATUS_W-1:0]      status;
      logic [LEVEL_W-1:0]       level;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEQ,
      ST_REP
   } state_type;

endpackage

// ----- hdl/fwr_stream_if.sv -----
// Valid/ready stream channel carrying one payload.
interface fwr_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/fwr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fwr_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 128,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- hdl/fifo_with_replace_all_unit.sv -----
// Top level: circular-buffer FIFO of signed words with enqueue, dequeue and replace-all.
//
//   port      dir   handshake      payload
//   req_chan  in    valid/ready    command, value, new_value
//   rsp_chan  out   valid/ready    data, status, level
//
// Enqueue, refused commands and unused codes: result registered directly on accept.
// Dequeue: the entry RAM read is registered first, then the result register.
// Replace: one RAM read port and one comparator walk the queue,
// writing each match back while the next entry is read.
// Reset (synchronous) clears the pointers and count; the entry RAM is not cleared.
// A request is taken only in idle with the result register free or being emptied.
module fifo_with_replace_all_unit #(
   parameter int DEPTH = fwr_pkg::DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   fwr_stream_if.sink   req_chan,
   fwr_stream_if.source rsp_chan
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   fwr_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   fwr_pkg::rsp_type   rsp_ff, rsp_in;

   // replace walk
   logic [IDX_W-1:0]                  rd_pos_ff, rd_pos_in;
   logic [IDX_W-1:0]                  wr_pos_ff, wr_pos_in;
   logic [CNT_W-1:0]                  remain_ff, remain_in;
   logic signed [fwr_pkg::DATA_W-1:0] match_ff, match_in;
   logic signed [fwr_pkg::DATA_W-1:0] new_ff, new_in;

   logic                       ram_wr_en;
   logic [IDX_W-1:0]           ram_wr_addr;
   logic [fwr_pkg::DATA_W-1:0] ram_wr_data;
   logic                       ram_rd_en;
   logic [IDX_W-1:0]           ram_rd_addr;
   logic [fwr_pkg::DATA_W-1:0] ram_rd_data;

   logic req_fire;

   function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(DEPTH - 1)) ? '0 : p + IDX_W'(1);
   endfunction

   fwr_ram #(
      .WIDTH (fwr_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready  = (state_ff == fwr_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire        = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      rd_pos_in    = rd_pos_ff;
      wr_pos_in    = wr_pos_ff;
      remain_in    = remain_ff;
      match_in     = match_ff;
      new_in       = new_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_pos_ff;
      ram_wr_data  = new_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = rd_pos_ff;

      unique case (state_ff)
         fwr_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.payload.command)
                  fwr_pkg::CMD_ENQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_in = '{fwr_pkg::ZERO_DATA, fwr_pkg::STAT_FULL,
                                   fwr_pkg::LEVEL_W'(count_ff)};
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = tail_ff;
                        ram_wr_data = req_chan.payload.value;
                        tail_in     = next_pos(tail_ff);
                        count_in    = count_ff + CNT_W'(1);
                        rsp_in      = '{fwr_pkg::ZERO_DATA, fwr_pkg::STAT_OK,
                                        fwr_pkg::LEVEL_W'(count_ff + CNT_W'(1))};
                     end
                  end
                  fwr_pkg::CMD_DEQUEUE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{fwr_pkg::EMPTY_DATA, fwr_pkg::STAT_EMPTY,
                                         fwr_pkg::LEVEL_W'(0)};
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = head_ff;
                        head_in     = next_pos(head_ff);
                        count_in    = count_ff - CNT_W'(1);
                        state_in    = fwr_pkg::ST_DEQ;
                     end
                  end
                  fwr_pkg::CMD_REPLACE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{fwr_pkg::ZERO_DATA, fwr_pkg::STAT_OK,
                                         fwr_pkg::LEVEL_W'(0)};
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = head_ff;
                        wr_pos_in   = head_ff;
                        rd_pos_in   = next_pos(head_ff);
                        remain_in   = count_ff - CNT_W'(1);
                        match_in    = req_chan.payload.value;
                        new_in      = req_chan.payload.new_value;
                        state_in    = fwr_pkg::ST_REP;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{fwr_pkg::ZERO_DATA, fwr_pkg::STAT_OK,
                                      fwr_pkg::LEVEL_W'(count_ff)};
                  end
               endcase
            end
         end
         fwr_pkg::ST_DEQ: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{ram_rd_data, fwr_pkg::STAT_OK, fwr_pkg::LEVEL_W'(count_ff)};
            state_in     = fwr_pkg::ST_IDLE;
         end
         fwr_pkg::ST_REP: begin
            // read data belongs to wr_pos_ff; write back on a match
            if (ram_rd_data == match_ff) begin
               ram_wr_en = 1'b1;
            end
            if (remain_ff != '0) begin
               ram_rd_en = 1'b1;
               wr_pos_in = rd_pos_ff;
               rd_pos_in = next_pos(rd_pos_ff);
               remain_in = remain_ff - CNT_W'(1);
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{fwr_pkg::ZERO_DATA, fwr_pkg::STAT_OK,
                                fwr_pkg::LEVEL_W'(count_ff)};
               state_in     = fwr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fwr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fwr_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      rd_pos_ff <= rd_pos_in;
      wr_pos_ff <= wr_pos_in;
      remain_ff <= remain_in;
      match_ff  <= match_in;
      new_ff    <= new_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("held count above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");

   a_req_followed: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_valid_ff || state_ff != fwr_pkg::ST_IDLE))
      else $error("request accepted with no result and no work pending");

   a_walk_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fwr_pkg::ST_REP) |-> !rsp_valid_ff)
      else $error("result pending during replace walk");
`endif

endmodule

// ----- tb/sv/fwr_queue_checker.sv -----
// Checker for the FIFO with replace-all: shadow queue, response prediction and compare.
module fwr_queue_checker #(
   parameter int DEPTH = fwr_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  fwr_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  fwr_pkg::rsp_type rsp_payload,
   output int               error_count,
   output int               outstanding
);
   import fwr_pkg::*;

   logic signed [DATA_W-1:0] shadow_store [DEPTH];
   int unsigned head_pos;
   int unsigned tail_pos;
   int unsigned held;
   rsp_type     expected_rsps [$];
   int unsigned rsp_index;

   task automatic flag_error(input string msg);
      $display("ERROR t=%0t rsp#%0d: %s", $realtime, rsp_index, msg);
      error_count++;
   endtask

   // Applies one request to the shadow queue and returns the response it must produce.
   function automatic rsp_type apply_command(input req_type req);
      rsp_type     rsp;
      int unsigned pos;
      rsp.data   = ZERO_DATA;
      rsp.status = STAT_OK;
      case (req.command)
         CMD_ENQUEUE: begin
            if (held == DEPTH) begin
               rsp.status = STAT_FULL;
            end else begin
               shadow_store[tail_pos] = req.value;
               tail_pos = (tail_pos + 1) % DEPTH;
               held++;
            end
         end
         CMD_DEQUEUE: begin
            if (held == 0) begin
               rsp.data   = EMPTY_DATA;
               rsp.status = STAT_EMPTY;
            end else begin
               rsp.data = shadow_store[head_pos];
               head_pos = (head_pos + 1) % DEPTH;
               held--;
            end
         end
         CMD_REPLACE: begin
            // walk only the held entries, oldest first
            pos = head_pos;
            repeat (held) begin
               if (shadow_store[pos] == req.value) shadow_store[pos] = req.new_value;
               pos = (pos + 1) % DEPTH;
            end
         end
         default: ;  // unused code leaves the queue alone
      endcase
      rsp.level = LEVEL_W'(held);
      return rsp;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         head_pos = 0;
         tail_pos = 0;
         held = 0;
         rsp_index = 0;
         expected_rsps.delete();
      end else begin
         // a response at this edge belongs to an earlier request, so compare first
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               flag_error("response with no request outstanding");
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.data !== want.data)
                  flag_error($sformatf("data %0d, want %0d", rsp_payload.data, want.data));
               if (rsp_payload.status !== want.status)
                  flag_error($sformatf("status %0d, want %0d", rsp_payload.status,
                                       want.status));
               if (rsp_payload.level !== want.level)
                  flag_error($sformatf("level %0d, want %0d", rsp_payload.level, want.level));
            end
            rsp_index++;
         end
         if (req_valid && req_ready) expected_rsps.push_back(apply_command(req_payload));
      end
      outstanding <= expected_rsps.size();
   end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top: clock, reset, request and response drivers, and the verdict.
module tb;
   import fwr_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AFTER  = 40;
   localparam int SETTLE_CYCLES   = 2 * DEPTH + 20;

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   error_count;
   int   outstanding;
   int   send_stretch = 0;
   int   recv_stretch = 0;

   fwr_stream_if #(.payload_type(req_type)) req_chan ();
   fwr_stream_if #(.payload_type(rsp_type)) rsp_chan ();

   fifo_with_replace_all_unit #(.DEPTH(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   fwr_queue_checker #(.DEPTH(DEPTH)) fifo_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_payload (req_chan.payload),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("fifo_with_replace_all_unit verification failed");
         $finish;
      end
   end

   // Wait before the next transfer; now and then a run of back-to-back transfers.
   function automatic int draw_gap(inout int stretch);
      if (stretch > 0) begin
         stretch--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) stretch = $urandom_range(8, 40);
      return $urandom_range(0, 13);
   endfunction

   // Half the values come from a small set so that replace finds matches.
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0: return EMPTY_DATA;
         1: return ZERO_DATA;
         2: return 32'sh7FFF_FFFF;
         3: return 32'sh8000_0000;
         4: return 32'sd100;
         5: return 32'sd7;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic signed [DATA_W-1:0] val,
                               input logic signed [DATA_W-1:0] nv);
      int gap;
      gap = draw_gap(send_stretch);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= '{command: cmd, value: val, new_value: nv};
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
   endtask

   initial begin : response_side
      int gap;
      int taken;
      rsp_chan.ready = 1'b0;
      taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         // one long hold-off while the queue is filling, so the request side backs up
         if (taken == HOLD_OFF_AFTER) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         gap = draw_gap(recv_stretch);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         taken++;
         @(negedge clock);
      end
   end

   initial begin : request_side
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed: empty cases, extremes, matches, unused code
      send_request(CMD_DEQUEUE, ZERO_DATA, ZERO_DATA);
      send_request(CMD_REPLACE, EMPTY_DATA, 32'sd1);
      send_request(CMD_UNUSED, EMPTY_DATA, EMPTY_DATA);
      send_request(CMD_ENQUEUE, 32'sh7FFF_FFFF, ZERO_DATA);
      send_request(CMD_ENQUEUE, 32'sh8000_0000, EMPTY_DATA);
      send_request(CMD_ENQUEUE, EMPTY_DATA, ZERO_DATA);
      send_request(CMD_ENQUEUE, ZERO_DATA, EMPTY_DATA);
      send_request(CMD_ENQUEUE, EMPTY_DATA, ZERO_DATA);
      send_request(CMD_ENQUEUE, 32'sd100, ZERO_DATA);
      send_request(CMD_REPLACE, EMPTY_DATA, 32'sh8000_0000);
      send_request(CMD_REPLACE, 32'sd12345, 32'sd1);
      send_request(CMD_UNUSED, ZERO_DATA, ZERO_DATA);
      repeat (6) send_request(CMD_DEQUEUE, EMPTY_DATA, EMPTY_DATA);
      send_request(CMD_DEQUEUE, ZERO_DATA, ZERO_DATA);
      send_request(CMD_ENQUEUE, 32'sd100, ZERO_DATA);
      send_request(CMD_REPLACE, 32'sd100, 32'sd100);
      send_request(CMD_DEQUEUE, ZERO_DATA, ZERO_DATA);

      // fill past full, with replaces over a growing queue
      for (int i = 0; i < DEPTH + 8; i++) begin
         if ($urandom_range(0, 7) == 0) send_request(CMD_REPLACE, pick_value(), pick_value());
         send_request(CMD_ENQUEUE, pick_value(), pick_value());
      end
      send_request(CMD_REPLACE, pick_value(), pick_value());
      send_request(CMD_REPLACE, EMPTY_DATA, 32'sd7);

      // drain past empty
      for (int i = 0; i < DEPTH + 24; i++) begin
         case ($urandom_range(0, 39))
            37:      send_request(CMD_ENQUEUE, pick_value(), $urandom);
            38:      send_request(CMD_REPLACE, pick_value(), pick_value());
            39:      send_request(CMD_UNUSED, $urandom, $urandom);
            default: send_request(CMD_DEQUEUE, $urandom, $urandom);
         endcase
      end

      // mixed traffic around a shallow level
      for (int i = 0; i < 125; i++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: send_request(CMD_ENQUEUE, pick_value(), $urandom);
            15, 16, 17, 18:          send_request(CMD_REPLACE, pick_value(), pick_value());
            19:                      send_request(CMD_UNUSED, $urandom, $urandom);
            default:                 send_request(CMD_DEQUEUE, $urandom, $urandom);
         endcase
      end
      req_chan.valid <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("fifo_with_replace_all_unit verification clean");
      end else begin
         $display("fifo_with_replace_all_unit verification failed");
      end
      $finish;
   end

endmodule
